FILE: src/rnc_pkg.sv
// ============================================================================
// rnc_pkg - shared types and codes for the reference-counted name cache
// Action and status codes, write commands, scan packet and broadcast types.
// ============================================================================
package rnc_pkg;

   localparam int SLOTS_DEFAULT = 16;
   // Index and count widths cover the largest supported table (256 slots).
   localparam int SLOT_IDX_W = 8;
   localparam int CNT_W      = 9;

   localparam logic [15:0] EMPTY_INDEX = 16'hFFFF;
   localparam logic [15:0] USE_MAX     = 16'hFFFF;

   localparam logic [2:0] ACT_ACQUIRE   = 3'd0;
   localparam logic [2:0] ACT_FIND      = 3'd1;
   localparam logic [2:0] ACT_RELEASE   = 3'd2;
   localparam logic [2:0] ACT_CLEAR     = 3'd3;
   localparam logic [2:0] ACT_INIT      = 3'd4;
   localparam logic [2:0] ACT_SET_COUNT = 3'd5;

   localparam logic [1:0] ST_HIT  = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_NONE = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   typedef enum logic {
      CTL_IDLE,
      CTL_SCAN
   } ctl_state_type;

   typedef enum logic [2:0] {
      WR_BUMP,
      WR_REPLACE,
      WR_RELEASE,
      WR_CLEAR,
      WR_INIT
   } wr_op_type;

   typedef struct packed {
      logic                    valid;
      wr_op_type               op;
      logic [SLOT_IDX_W-1:0]   slot;
      logic [63:0]             name;
      logic [14:0]             newq;
   } wr_cmd_type;

   typedef struct packed {
      logic                    valid;
      logic                    hit;
      logic                    have;
      logic [SLOT_IDX_W-1:0]   best_slot;
      logic signed [15:0]      best_q;
   } scan_pkt_type;

   typedef struct packed {
      logic [63:0]             name;
      logic                    find;
      logic [CNT_W-1:0]        active;
   } bcast_type;

endpackage

FILE: src/rnc_cell.sv
// ============================================================================
// rnc_cell - one cache slot of the scan chain
// Holds name, use count and load index; updates the passing scan packet.
// ============================================================================
module rnc_cell
   import rnc_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  bcast_type    bcast,
   input  wr_cmd_type   wr,
   input  scan_pkt_type pkt_in,
   output scan_pkt_type pkt_out
);

   logic [63:0]  name_ff, name_in;
   logic [15:0]  use_ff, use_in;
   logic [15:0]  li_ff, li_in;
   scan_pkt_type pkt_ff, pkt_in_next;

   logic         part;
   logic         match;
   logic         sel;
   logic [15:0]  bumped;

   always_comb begin
      part  = CNT_W'(IDX) < bcast.active;
      match = (name_ff == bcast.name) && (!bcast.find || (li_ff != EMPTY_INDEX));

      pkt_in_next = pkt_in;
      if (pkt_in.valid && part && !pkt_in.hit) begin
         if (match) begin
            pkt_in_next.hit       = 1'b1;
            pkt_in_next.best_slot = SLOT_IDX_W'(IDX);
         end else if (!bcast.find && (use_ff == 16'd0) &&
                      (!pkt_in.have || ($signed(li_ff) < pkt_in.best_q))) begin
            pkt_in_next.have      = 1'b1;
            pkt_in_next.best_slot = SLOT_IDX_W'(IDX);
            pkt_in_next.best_q    = $signed(li_ff);
         end
      end
   end

   always_comb begin
      sel     = wr.valid && (wr.slot == SLOT_IDX_W'(IDX));
      bumped  = (use_ff == USE_MAX) ? use_ff : use_ff + 16'd1;
      name_in = name_ff;
      use_in  = use_ff;
      li_in   = li_ff;
      if (sel) begin
         case (wr.op)
            WR_BUMP: begin
               use_in = bumped;
            end
            WR_REPLACE: begin
               use_in  = bumped;
               name_in = wr.name;
               li_in   = {1'b0, wr.newq};
            end
            WR_RELEASE: begin
               use_in = 16'd0;
            end
            WR_CLEAR: begin
               name_in = 64'd0;
               use_in  = 16'd0;
               li_in   = EMPTY_INDEX;
            end
            WR_INIT: begin
               name_in = wr.name;
               use_in  = 16'd0;
               li_in   = EMPTY_INDEX;
            end
            default: begin
               use_in = use_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_ff      <= 64'd0;
         use_ff       <= 16'd0;
         li_ff        <= EMPTY_INDEX;
         pkt_ff.valid <= 1'b0;
      end else begin
         name_ff <= name_in;
         use_ff  <= use_in;
         li_ff   <= li_in;
         pkt_ff  <= pkt_in_next;
      end
   end

   assign pkt_out = pkt_ff;

endmodule

FILE: src/rnc_ctrl.sv
// ============================================================================
// rnc_ctrl - request sequencer for the name cache
// Launches scans, applies slot writes and issues one response per request.
// ============================================================================
module rnc_ctrl
   import rnc_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic [2:0]    req_action,
   input  logic [3:0]    req_slot,
   input  logic [63:0]   req_entry_name,
   input  logic [14:0]   req_new_queue_index,
   input  logic [4:0]    req_count_value,
   output logic          rsp_strobe,
   output logic [1:0]    rsp_status,
   output logic [3:0]    rsp_result_slot,
   output bcast_type     bcast,
   output wr_cmd_type    wr,
   output scan_pkt_type  launch,
   input  scan_pkt_type  tail
);

   ctl_state_type         state_ff, state_in;
   logic [63:0]           name_ff, name_in;
   logic                  find_ff, find_in;
   logic [14:0]           newq_ff, newq_in;
   logic [CNT_W-1:0]      active_ff, active_in;
   scan_pkt_type          launch_ff, launch_in;
   wr_cmd_type            wr_ff, wr_in;
   logic                  strobe_ff, strobe_in;
   logic [1:0]            status_ff, status_in;
   logic [3:0]            rslot_ff, rslot_in;
   logic                  slot_bad;

   always_comb begin
      state_in  = state_ff;
      name_in   = name_ff;
      find_in   = find_ff;
      newq_in   = newq_ff;
      active_in = active_ff;
      launch_in = '0;
      wr_in     = wr_ff;
      wr_in.valid = 1'b0;
      strobe_in = 1'b0;
      status_in = status_ff;
      rslot_in  = rslot_ff;
      slot_bad  = 32'(req_slot) >= SLOTS;

      case (state_ff)
         CTL_IDLE: begin
            if (start) begin
               case (req_action)
                  ACT_ACQUIRE, ACT_FIND: begin
                     name_in         = req_entry_name;
                     find_in         = (req_action == ACT_FIND);
                     newq_in         = req_new_queue_index;
                     launch_in.valid = 1'b1;
                     state_in        = CTL_SCAN;
                  end
                  ACT_RELEASE, ACT_CLEAR, ACT_INIT: begin
                     strobe_in = 1'b1;
                     rslot_in  = req_slot;
                     if (slot_bad) begin
                        status_in = ST_NONE;
                     end else begin
                        status_in   = ST_DONE;
                        wr_in.valid = 1'b1;
                        wr_in.slot  = SLOT_IDX_W'(req_slot);
                        wr_in.name  = req_entry_name;
                        if (req_action == ACT_RELEASE) begin
                           wr_in.op = WR_RELEASE;
                        end else if (req_action == ACT_CLEAR) begin
                           wr_in.op = WR_CLEAR;
                        end else begin
                           wr_in.op = WR_INIT;
                        end
                     end
                  end
                  ACT_SET_COUNT: begin
                     active_in = (32'(req_count_value) > SLOTS) ?
                                 CNT_W'(SLOTS) : CNT_W'(req_count_value);
                     strobe_in = 1'b1;
                     status_in = ST_DONE;
                     rslot_in  = 4'd0;
                  end
                  default: begin
                     strobe_in = 1'b1;
                     status_in = ST_NONE;
                     rslot_in  = 4'd0;
                  end
               endcase
            end
         end
         CTL_SCAN: begin
            if (tail.valid) begin
               state_in  = CTL_IDLE;
               strobe_in = 1'b1;
               if (tail.hit) begin
                  status_in   = ST_HIT;
                  rslot_in    = tail.best_slot[3:0];
                  wr_in.valid = !find_ff;
                  wr_in.op    = WR_BUMP;
                  wr_in.slot  = tail.best_slot;
               end else if (!find_ff && tail.have) begin
                  status_in   = ST_MISS;
                  rslot_in    = tail.best_slot[3:0];
                  wr_in.valid = 1'b1;
                  wr_in.op    = WR_REPLACE;
                  wr_in.slot  = tail.best_slot;
                  wr_in.name  = name_ff;
                  wr_in.newq  = newq_ff;
               end else begin
                  status_in = ST_NONE;
                  rslot_in  = 4'd0;
               end
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= CTL_IDLE;
         active_ff       <= '0;
         launch_ff.valid <= 1'b0;
         wr_ff.valid     <= 1'b0;
         strobe_ff       <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         launch_ff <= launch_in;
         wr_ff     <= wr_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      name_ff   <= name_in;
      find_ff   <= find_in;
      newq_ff   <= newq_in;
      status_ff <= status_in;
      rslot_ff  <= rslot_in;
   end

   assign busy            = (state_ff != CTL_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_result_slot = rslot_ff;
   assign bcast.name      = name_ff;
   assign bcast.find      = find_ff;
   assign bcast.active    = active_ff;
   assign wr              = wr_ff;
   assign launch          = launch_ff;

endmodule

FILE: src/refcounted_name_cache_top.sv
// ============================================================================
// refcounted_name_cache_top - reference-counted name cache, chain of slots
// Acquire/find scan a row of slot cells; release, clear and init write one slot.
// ============================================================================
// Usage: a request transaction is taken when start is high and busy is low.
// Every request yields exactly one response, shown for one cycle with
// rsp_strobe high; the receiver cannot stall, so sample it when it appears.
// Release, clear, init, set-count and unknown actions answer in the next cycle and
// the block is ready again at once. Acquire and find send a scan packet down
// the row of SLOTS slot cells, one cell per cycle, and answer after the packet
// leaves the last cell; busy stays high meanwhile.
// The slot update caused by a request (use-count bump, replacement, release,
// clear, init) lands on the edge after its response, before any later scan
// can read that slot.
// ============================================================================
module refcounted_name_cache_top
   import rnc_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [2:0]   req_action,
   input  logic [3:0]   req_slot,
   input  logic [63:0]  req_entry_name,
   input  logic [14:0]  req_new_queue_index,
   input  logic [4:0]   req_count_value,
   output logic         rsp_strobe,
   output logic [1:0]   rsp_status,
   output logic [3:0]   rsp_result_slot
);

   bcast_type    bcast;
   wr_cmd_type   wr;
   // chain[i] feeds cell i; chain[SLOTS] returns to the sequencer
   scan_pkt_type chain [SLOTS+1];

   rnc_ctrl #(
      .SLOTS(SLOTS)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_slot            (req_slot),
      .req_entry_name      (req_entry_name),
      .req_new_queue_index (req_new_queue_index),
      .req_count_value     (req_count_value),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_result_slot     (rsp_result_slot),
      .bcast               (bcast),
      .wr                  (wr),
      .launch              (chain[0]),
      .tail                (chain[SLOTS])
   );

   // Each cell compares its name against the broadcast request, then passes
   // the packet (first hit, best free slot so far) to its neighbor.
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      rnc_cell #(
         .IDX(i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .bcast   (bcast),
         .wr      (wr),
         .pkt_in  (chain[i]),
         .pkt_out (chain[i+1])
      );
   end

endmodule

FILE: src/rnc_checker.sv
// ============================================================================
// rnc_checker - port-level checks for the name cache
// Relates request acceptance, busy and the response strobe over time.
// ============================================================================
module rnc_checker
   import rnc_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   // an accepted transaction either answers next cycle or starts a scan
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("accepted request neither answered nor scanning");

   // scan responses come as busy drops, never while busy
   a_no_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("response strobe while busy");

   a_busy_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an accepted request");

   a_fall_answers: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("scan finished without a response");

endmodule

bind refcounted_name_cache_top rnc_checker u_rnc_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);
